// ===== src/srt_pkg.sv =====
package srt_pkg;

  localparam int SPEED_WIDTH_DEF = 24;
  localparam int TICK_W          = 16;
  localparam int RATE_W          = 23;
  localparam int REM_W           = 25;
  localparam int MAG_W           = 24;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 23;

  localparam logic [TICK_W-1:0] TICK_RESET = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_AWAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_TOWARD = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_TRACK = 1'b1;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  dividend;
    logic [TICK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MAG_W-1:0]  quot;
    logic [TICK_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== src/srt_div.sv =====
module srt_div (
  input  logic             clk,
  input  logic             rst_n,
  input  srt_pkg::div_req_t req,
  output srt_pkg::div_rsp_t rsp
);

  localparam int QW = srt_pkg::MAG_W;
  localparam int DW = srt_pkg::TICK_W;
  localparam int CW = $clog2(QW + 1);

  logic          act_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [QW-1:0] quot_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dsr_r;

  logic [DW:0]   trial;
  logic          fits;
  logic [DW:0]   diff;

  // one quotient bit a cycle, restoring
  assign trial = {rem_r, quot_r[QW-1]};
  assign fits  = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        act_r  <= 1'b1;
        cnt_r  <= '0;
        quot_r <= req.dividend;
        rem_r  <= '0;
        dsr_r  <= req.divisor;
      end else if (act_r) begin
        quot_r <= {quot_r[QW-2:0], fits};
        rem_r  <= fits ? diff[DW-1:0] : trial[DW-1:0];
        if (cnt_r == CW'(QW - 1)) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== src/speed_ramp_tracker_unit.sv =====
// Speed ramp tracker: follows a goal speed under an acceleration limit.
//
// Input channel (in_valid/in_ready): in_command selects load (0), which sets
// the tracked speed to in_speed_value and clears the remainder, or track (1),
// which moves the tracked speed one control tick toward the goal
// in_speed_value. Every item gives one result item on out_valid/out_ready
// carrying the tracked speed after that item.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 tick rate,
// 1 rate away from zero, 2 rate toward zero; other indexes are ignored.
// Write it only while the block is idle.
//
// A track item that moves the speed goes from idle to the divide state, where
// the 24-step serial divider (one quotient bit a cycle) runs, and then to the
// final state; load items and track items already at the goal go straight
// from idle to the final state.
// One item at a time: in_ready is low from accept until the result has been
// placed in the output register. A stalled receiver holds the result there and
// the next item waits in the final state until the register frees.
// Reset: tick rate 1000, both rates 0, speed and remainder 0, no result held.
module speed_ramp_tracker_unit #(
  parameter int SPEED_WIDTH = srt_pkg::SPEED_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic signed [SPEED_WIDTH-1:0]       in_speed_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SPEED_WIDTH-1:0]       out_speed_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SW = SPEED_WIDTH;
  localparam int RW = srt_pkg::REM_W;
  localparam int QW = srt_pkg::MAG_W;
  localparam int TW = srt_pkg::TICK_W;
  localparam int WW = ((SW > RW) ? SW : RW) + 2;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} state_t;

  state_t                   state_r;
  logic [TW-1:0]            tick_r;
  logic [srt_pkg::RATE_W-1:0] rate_away_r;
  logic [srt_pkg::RATE_W-1:0] rate_toward_r;
  logic signed [SW-1:0]     speed_r;
  logic signed [RW-1:0]     rem_r;
  logic signed [SW-1:0]     goal_r;
  logic                     up_r;
  logic                     neg_r;
  logic                     out_valid_r;
  logic signed [SW-1:0]     out_speed_r;

  srt_pkg::div_req_t        div_req;
  srt_pkg::div_rsp_t        div_rsp;

  logic                     accept;
  logic                     up;
  logic                     moves;
  logic                     away;
  logic [srt_pkg::RATE_W-1:0] mag;
  logic signed [RW-1:0]     accel;
  logic signed [RW-1:0]     sum;
  logic signed [RW-1:0]     sum_abs;
  logic signed [WW-1:0]     q_ext;
  logic signed [WW-1:0]     speed_ext;
  logic signed [WW-1:0]     goal_ext;
  logic signed [WW-1:0]     new_speed;
  logic signed [RW-1:0]     r_ext;
  logic                     hit_goal;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign up    = in_speed_value > speed_r;
  assign moves = in_speed_value != speed_r;
  assign away  = up ? !speed_r[SW-1] : (speed_r[SW-1] || (speed_r == '0));
  assign mag   = away ? rate_away_r : rate_toward_r;
  assign accel = $signed({{(RW-srt_pkg::RATE_W){1'b0}}, mag});
  assign sum   = up ? rem_r + accel : rem_r - accel;
  assign sum_abs = sum[RW-1] ? -sum : sum;

  assign div_req.start    = accept && (in_command == srt_pkg::CMD_TRACK) && moves;
  assign div_req.dividend = sum_abs[QW-1:0];
  assign div_req.divisor  = (tick_r == '0) ? TW'(1) : tick_r;

  srt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign q_ext     = $signed({{(WW-QW){1'b0}}, div_rsp.quot});
  assign speed_ext = WW'(speed_r);
  assign goal_ext  = WW'(goal_r);
  assign new_speed = neg_r ? speed_ext - q_ext : speed_ext + q_ext;
  assign r_ext     = neg_r ? -$signed({{(RW-TW){1'b0}}, div_rsp.rem})
                           :  $signed({{(RW-TW){1'b0}}, div_rsp.rem});
  assign hit_goal  = up_r ? (new_speed >= goal_ext) : (new_speed <= goal_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      tick_r        <= srt_pkg::TICK_RESET;
      rate_away_r   <= '0;
      rate_toward_r <= '0;
      speed_r       <= '0;
      rem_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srt_pkg::CFG_TICK_RATE:   tick_r        <= cfg_data[TW-1:0];
          srt_pkg::CFG_RATE_AWAY:   rate_away_r   <= cfg_data;
          srt_pkg::CFG_RATE_TOWARD: rate_toward_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_command == srt_pkg::CMD_LOAD) begin
              speed_r <= in_speed_value;
              rem_r   <= '0;
              state_r <= ST_FIN;
            end else if (moves) begin
              goal_r  <= in_speed_value;
              up_r    <= up;
              neg_r   <= sum[RW-1];
              state_r <= ST_DIV;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            if (hit_goal) begin
              speed_r <= goal_r;
              rem_r   <= '0;
            end else begin
              speed_r <= new_speed[SW-1:0];
              rem_r   <= r_ext;
            end
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_speed_r <= speed_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_speed_out = out_speed_r;

  a_load_sets_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == srt_pkg::CMD_LOAD) |=>
      (speed_r == $past(in_speed_value) && rem_r == '0))
    else $error("load item did not set the tracked speed");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r == ST_FIN) && state_r == ST_IDLE))
    else $error("result item raised outside the final state");

endmodule
